### src/wsd_pkg.sv
// Shared constants, reset values and register codes for the windowed SNR detector.
package wsd_pkg;

    localparam int POWER_W        = 24;
    localparam int THR_W          = 16;
    localparam int SCORE_THR_W    = 32;
    localparam int SCORE_W        = 40;
    localparam int WLEN_W         = 9;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int WINDOW_MAX_DEF = 256;

    // Sigma is only formed once the window holds more than this many samples.
    localparam int MIN_FILL = 5;

    localparam logic [THR_W-1:0]       HIGH_SIG_RST  = 16'd1280;
    localparam logic [THR_W-1:0]       SIG_RST       = 16'd1024;
    localparam logic [THR_W-1:0]       NOSIG_RST     = 16'd512;
    localparam logic [SCORE_THR_W-1:0] SCORE_THR_RST = 32'd128000;
    localparam logic [THR_W-1:0]       MEAN_MIN_RST  = 16'd256;
    localparam logic [THR_W-1:0]       STD_MIN_RST   = 16'd256;
    localparam logic [THR_W-1:0]       STEP_RST      = 16'd1024;
    localparam logic [WLEN_W-1:0]      WLEN_RST      = 9'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_SIG,
        CFG_SIG,
        CFG_NOSIG,
        CFG_SCORE_THR,
        CFG_MEAN_RATIO,
        CFG_STD_RATIO,
        CFG_STEP,
        CFG_WLEN
    } t_cfg_idx;

endpackage

### src/windowed_snr_detector.sv
// Windowed SNR detector: sliding-window sigma scoring of one candidate row per beat stream.
// Steps: each evicted sample is read and subtracted, then the check repeats; then a
// bit-serial square; past five samples n*Q and S*S, and up to three threshold tests
// (t*t, t^2 times the variance term, compare, next test). A row end adds two ratio
// tests. One shift-add multiplier at one bit per cycle serves them all; the input
// stalls while a beat is in work, so a new beat is taken only once the last is done.
// Reset (synchronous, active low) restores the register defaults and empties the window.
module windowed_snr_detector #(
    parameter int WINDOW_MAX = wsd_pkg::WINDOW_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wsd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // sample channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [wsd_pkg::POWER_W-1:0]      i_power,
    input  logic                             i_last_sample,
    input  logic [wsd_pkg::POWER_W-1:0]      i_row_mean,
    input  logic [wsd_pkg::POWER_W-1:0]      i_row_smoothed_mean,
    input  logic [wsd_pkg::POWER_W-1:0]      i_row_stddev,
    input  logic [wsd_pkg::POWER_W-1:0]      i_row_smoothed_stddev,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_accepted,
    output logic signed [wsd_pkg::SCORE_W-1:0] o_total_score
);
    import wsd_pkg::*;

    // Widths that follow from the window depth.
    localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FW     = $clog2(WINDOW_MAX + 1);
    localparam int SW     = POWER_W + FW;              // running sum
    localparam int SQW    = 2 * POWER_W;               // one squared sample
    localparam int QW     = SQW + FW;                  // running sum of squares
    localparam int NQW    = QW + FW;                   // n * Q, same width as S * S
    localparam int DW     = NQW + 1;                   // n*Q - S*S
    localparam int MW     = (SW > 31) ? SW : 31;       // multiplier operand
    localparam int ACC_W  = DW + MW;                   // product accumulator
    localparam int CMP_W  = ACC_W + 1;
    localparam int CW     = (FW > WLEN_W) ? FW : WLEN_W;
    localparam int EW     = SQW + POWER_W;             // stored entry: square and sample
    localparam int D_W    = THR_W + 2;                 // score delta, up to three steps
    localparam int OW     = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_EVRD, S_EVSUB, S_SQ, S_MUL, S_WR, S_DZ, S_THR, S_CMP,
        S_SCORE, S_FIN, S_RATIO, S_RCMP, S_RREC, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        M_SQ, M_NQ, M_SS, M_TT, M_TD, M_RATIO
    } t_tag;

    typedef enum logic [1:0] {
        SEL_HIGH, SEL_SIG, SEL_NOSIG
    } t_sel;

    t_state r_state;
    t_tag   r_tag;
    t_sel   r_sel;

    // Configuration registers.
    logic [THR_W-1:0]       r_hi_thr, r_sig_thr, r_nosig_thr, r_mean_min, r_std_min, r_step;
    logic [SCORE_THR_W-1:0] r_score_thr;
    logic [WLEN_W-1:0]      r_wlen;

    // Latched beat.
    logic [POWER_W-1:0] r_pw, r_rmean, r_rsmean, r_rstd, r_rsstd;
    logic               r_last;

    // Window state.
    logic [EW-1:0]      r_mem [WINDOW_MAX];
    logic [EW-1:0]      r_rd;
    logic [FW-1:0]      r_fill;
    logic [AW-1:0]      r_head;
    logic [SW-1:0]      r_sum;
    logic [QW-1:0]      r_q;
    logic [NQW-1:0]     r_nq;
    logic [NQW-1:0]     r_ss;
    logic [DW-1:0]      r_dvar;
    logic signed [SCORE_W-1:0] r_score;
    logic signed [D_W-1:0]     r_delta;

    // Shift-add multiplier.
    logic [ACC_W-1:0] r_mcand, r_acc;
    logic [MW-1:0]    r_mplier;

    // Ratio tests.
    logic r_second, r_r1, r_rpass, r_rok;

    // Output register.
    logic                      r_ovalid, r_oacc;
    logic signed [SCORE_W-1:0] r_oscore;

    // ---------------------------------------------------------------------------------
    // Window capacity: zero acts as one, anything above the depth acts as the depth.
    logic [CW-1:0] w_wlen_ext, w_cap;
    logic          w_evict;
    always_comb begin
        w_wlen_ext = CW'(r_wlen);
        if (r_wlen == '0) begin
            w_cap = CW'(1);
        end else if (w_wlen_ext > CW'(WINDOW_MAX)) begin
            w_cap = CW'(WINDOW_MAX);
        end else begin
            w_cap = w_wlen_ext;
        end
        w_evict = (CW'(r_fill) >= w_cap);
    end

    // Oldest entry sits fill places behind the head, modulo the depth.
    logic [OW-1:0] w_old_raw, w_old_mod;
    logic [AW-1:0] w_old, w_head_next;
    always_comb begin
        w_old_raw = OW'(r_head) + OW'(WINDOW_MAX) - OW'(r_fill);
        w_old_mod = (w_old_raw >= OW'(WINDOW_MAX)) ? (w_old_raw - OW'(WINDOW_MAX)) : w_old_raw;
        w_old     = w_old_mod[AW-1:0];
        w_head_next = (r_head == AW'(WINDOW_MAX - 1)) ? '0 : (r_head + AW'(1));
    end

    // Score deltas.
    logic signed [D_W-1:0] w_step1, w_step3, w_stepn;
    assign w_step1 = {{2{r_step[THR_W-1]}}, r_step};
    assign w_step3 = w_step1 + (w_step1 <<< 1);
    assign w_stepn = -w_step1;

    // Saturating score update.
    logic signed [SCORE_W:0]   w_ssum;
    logic signed [SCORE_W-1:0] w_ssat;
    always_comb begin
        w_ssum = {r_score[SCORE_W-1], r_score} + {{(SCORE_W + 1 - D_W){r_delta[D_W-1]}}, r_delta};
        if (!w_ssum[SCORE_W] && w_ssum[SCORE_W-1]) begin
            w_ssat = {1'b0, {(SCORE_W - 1){1'b1}}};
        end else if (w_ssum[SCORE_W] && !w_ssum[SCORE_W-1]) begin
            w_ssat = {1'b1, {(SCORE_W - 1){1'b0}}};
        end else begin
            w_ssat = w_ssum[SCORE_W-1:0];
        end
    end

    // Threshold under test and the squared sigma comparison:
    // (256*S)^2 against 2 * t^2 * (n*Q - S*S).
    logic [THR_W-1:0] w_thr;
    logic [CMP_W-1:0] w_lhs, w_rhs;
    always_comb begin
        case (r_sel)
            SEL_HIGH: w_thr = r_hi_thr;
            SEL_SIG:  w_thr = r_sig_thr;
            default:  w_thr = r_nosig_thr;
        endcase
        w_lhs = CMP_W'({r_ss, 16'b0});
        w_rhs = {r_acc, 1'b0};
    end

    // Ratio test operands: first the mean pair, then the deviation pair.
    logic [POWER_W-1:0] w_rnum, w_rden;
    logic [THR_W-1:0]   w_rthr;
    logic               w_rshort, w_rpass_short, w_rpass_mul;
    always_comb begin
        w_rnum = r_second ? r_rstd   : r_rmean;
        w_rden = r_second ? r_rsstd  : r_rsmean;
        w_rthr = r_second ? r_std_min : r_mean_min;
        // A zero denominator or a threshold at or below zero needs no product.
        w_rshort      = (w_rden == '0) || w_rthr[THR_W-1] || (w_rthr == '0);
        w_rpass_short = ((w_rden != '0) && w_rthr[THR_W-1]) ? 1'b1 : (w_rnum != '0);
        w_rpass_mul   = (ACC_W'({w_rnum, 8'b0}) > r_acc);
    end

    logic w_out_free;
    assign w_out_free = !r_ovalid || !i_out_stall;

    // ---------------------------------------------------------------------------------
    // Window memory: one write port at the head, one registered read at the oldest entry.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            r_mem[r_head] <= {r_acc[SQW-1:0], r_pw};
        end
        r_rd <= r_mem[w_old];
    end

    // ---------------------------------------------------------------------------------
    // Sequencer. Each beat evicts what no longer fits, squares the new sample, updates
    // the running sums, then past five samples walks the sigma tests through the shared multiplier.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tag       <= M_SQ;
            r_sel       <= SEL_HIGH;
            r_fill      <= '0;
            r_head      <= '0;
            r_sum       <= '0;
            r_q         <= '0;
            r_score     <= '0;
            r_second    <= 1'b0;
            r_ovalid    <= 1'b0;
            r_hi_thr    <= HIGH_SIG_RST;
            r_sig_thr   <= SIG_RST;
            r_nosig_thr <= NOSIG_RST;
            r_score_thr <= SCORE_THR_RST;
            r_mean_min  <= MEAN_MIN_RST;
            r_std_min   <= STD_MIN_RST;
            r_step      <= STEP_RST;
            r_wlen      <= WLEN_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_HIGH_SIG:   r_hi_thr    <= i_cfg_data[THR_W-1:0];
                    CFG_SIG:        r_sig_thr   <= i_cfg_data[THR_W-1:0];
                    CFG_NOSIG:      r_nosig_thr <= i_cfg_data[THR_W-1:0];
                    CFG_SCORE_THR:  r_score_thr <= i_cfg_data[SCORE_THR_W-1:0];
                    CFG_MEAN_RATIO: r_mean_min  <= i_cfg_data[THR_W-1:0];
                    CFG_STD_RATIO:  r_std_min   <= i_cfg_data[THR_W-1:0];
                    CFG_STEP:       r_step      <= i_cfg_data[THR_W-1:0];
                    CFG_WLEN:       r_wlen      <= i_cfg_data[WLEN_W-1:0];
                endcase
            end

            // The output stage publishes its next verdict itself, so it only drains here.
            if (r_ovalid && !i_out_stall && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pw     <= i_power;
                        r_last   <= i_last_sample;
                        r_rmean  <= i_row_mean;
                        r_rsmean <= i_row_smoothed_mean;
                        r_rstd   <= i_row_stddev;
                        r_rsstd  <= i_row_smoothed_stddev;
                        r_state  <= S_EVRD;
                    end
                end
                S_EVRD: begin
                    r_state <= w_evict ? S_EVSUB : S_SQ;
                end
                S_EVSUB: begin
                    r_sum   <= r_sum - SW'(r_rd[POWER_W-1:0]);
                    r_q     <= r_q - QW'(r_rd[EW-1:POWER_W]);
                    r_fill  <= r_fill - FW'(1);
                    r_state <= S_EVRD;
                end
                S_SQ: begin
                    r_mcand  <= ACC_W'(r_pw);
                    r_mplier <= MW'(r_pw);
                    r_acc    <= '0;
                    r_tag    <= M_SQ;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    if (r_mplier != '0) begin
                        if (r_mplier[0]) begin
                            r_acc <= r_acc + r_mcand;
                        end
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end else begin
                        unique case (r_tag)
                            M_SQ: r_state <= S_WR;
                            M_NQ: begin
                                r_nq     <= r_acc[NQW-1:0];
                                r_mcand  <= ACC_W'(r_sum);
                                r_mplier <= MW'(r_sum);
                                r_acc    <= '0;
                                r_tag    <= M_SS;
                            end
                            M_SS: begin
                                r_ss    <= r_acc[NQW-1:0];
                                r_state <= S_DZ;
                            end
                            M_TT: begin
                                r_mcand  <= ACC_W'(r_dvar);
                                r_mplier <= MW'(r_acc[30:0]);
                                r_acc    <= '0;
                                r_tag    <= M_TD;
                            end
                            M_TD:    r_state <= S_CMP;
                            M_RATIO: r_state <= S_RCMP;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WR: begin
                    r_head <= w_head_next;
                    r_fill <= r_fill + FW'(1);
                    r_sum  <= r_sum + SW'(r_pw);
                    r_q    <= r_q + QW'(r_acc[SQW-1:0]);
                    if (r_fill >= FW'(MIN_FILL)) begin
                        // n*Q with the updated sums; the count goes in as the multiplier.
                        r_mcand  <= ACC_W'(r_q + QW'(r_acc[SQW-1:0]));
                        r_mplier <= MW'(r_fill + FW'(1));
                        r_acc    <= '0;
                        r_tag    <= M_NQ;
                        r_state  <= S_MUL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DZ: begin
                    r_dvar <= DW'(r_nq) - DW'(r_ss);
                    if (r_nq == r_ss) begin
                        // Zero variance counts as above the high threshold.
                        r_delta <= w_step3;
                        r_state <= S_SCORE;
                    end else begin
                        r_sel   <= SEL_HIGH;
                        r_state <= S_THR;
                    end
                end
                S_THR: begin
                    if (r_sel == SEL_HIGH && w_thr[THR_W-1]) begin
                        r_delta <= w_step3;
                        r_state <= S_SCORE;
                    end else if (r_sel == SEL_SIG && w_thr[THR_W-1]) begin
                        r_delta <= w_step1;
                        r_state <= S_SCORE;
                    end else if (r_sel == SEL_NOSIG && (w_thr[THR_W-1] || w_thr == '0)) begin
                        // Sigma is never negative, so nothing lies below such a threshold.
                        r_delta <= '0;
                        r_state <= S_SCORE;
                    end else begin
                        r_mcand  <= ACC_W'(w_thr[THR_W-2:0]);
                        r_mplier <= MW'(w_thr[THR_W-2:0]);
                        r_acc    <= '0;
                        r_tag    <= M_TT;
                        r_state  <= S_MUL;
                    end
                end
                S_CMP: begin
                    unique case (r_sel)
                        SEL_HIGH: begin
                            if (w_lhs > w_rhs) begin
                                r_delta <= w_step3;
                                r_state <= S_SCORE;
                            end else begin
                                r_sel   <= SEL_SIG;
                                r_state <= S_THR;
                            end
                        end
                        SEL_SIG: begin
                            if (w_lhs > w_rhs) begin
                                r_delta <= w_step1;
                                r_state <= S_SCORE;
                            end else begin
                                r_sel   <= SEL_NOSIG;
                                r_state <= S_THR;
                            end
                        end
                        default: begin
                            r_delta <= (w_lhs < w_rhs) ? w_stepn : '0;
                            r_state <= S_SCORE;
                        end
                    endcase
                end
                S_SCORE: begin
                    r_score <= w_ssat;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_second <= 1'b0;
                    r_state  <= r_last ? S_RATIO : S_IDLE;
                end
                S_RATIO: begin
                    if (w_rshort) begin
                        r_rpass <= w_rpass_short;
                        r_state <= S_RREC;
                    end else begin
                        r_mcand  <= ACC_W'(w_rden);
                        r_mplier <= MW'(w_rthr[THR_W-2:0]);
                        r_acc    <= '0;
                        r_tag    <= M_RATIO;
                        r_state  <= S_MUL;
                    end
                end
                S_RCMP: begin
                    r_rpass <= w_rpass_mul;
                    r_state <= S_RREC;
                end
                S_RREC: begin
                    if (!r_second) begin
                        r_r1     <= r_rpass;
                        r_second <= 1'b1;
                        r_state  <= S_RATIO;
                    end else begin
                        r_rok   <= r_r1 && r_rpass;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_oacc   <= r_rok &&
                                    (r_score > $signed({{(SCORE_W - SCORE_THR_W){
                                                           r_score_thr[SCORE_THR_W-1]}},
                                                        r_score_thr}));
                        r_oscore <= r_score;
                        // The row is finished: empty the window and restart the score.
                        r_fill   <= '0;
                        r_head   <= '0;
                        r_sum    <= '0;
                        r_q      <= '0;
                        r_score  <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_accepted    = r_oacc;
    assign o_total_score = r_oscore;

    // ---------------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW_MAX))
        else $error("window fill beyond depth");

    a_evict_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVSUB) |-> (r_fill != '0))
        else $error("eviction from an empty window");

    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (o_out_valid && r_fill == '0 && r_score == '0))
        else $error("row end did not publish and clear");

    a_square_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_tag == M_SQ) |-> (r_mplier[MW-1:POWER_W] == '0))
        else $error("square operand wider than a sample");

endmodule
